// ----- sv/tadpcm_pkg.sv -----
// Shared types and constants for the two-tap ADPCM frame decoder.
// Used by the channel interface instances, the arithmetic unit and the top level.
package tadpcm_pkg;

  localparam int FRAME_BYTES_N     = 18;
  localparam int SAMPLES_PER_FRAME = 32;
  localparam int MAX_CHANNELS      = 2;

  localparam logic [4:0] FRAME_BYTES = 5'(FRAME_BYTES_N);

  localparam logic signed [15:0] COEF_FIRST_RESET  = 16'sd7298;
  localparam logic signed [15:0] COEF_SECOND_RESET = -16'sd3535;

  localparam logic signed [21:0] SUM_MIN    = -22'sd32768;
  localparam logic signed [21:0] SUM_MAX    = 22'sd32767;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;

  localparam logic [1:0] CFG_COEF_FIRST    = 2'd0;
  localparam logic [1:0] CFG_COEF_SECOND   = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] CFG_TOTAL         = 2'd3;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               channel_id;
    logic [31:0]        sample_index;
    logic               last_of_byte;
    logic               stream_done;
  } res_word_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [31:0] wdata;
  } cfg_word_t;

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_MAC,
    ALU_FINISH
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic signed [16:0] op_a;
    logic signed [16:0] op_b;
  } alu_req_t;

endpackage

// ----- sv/tadpcm_chan_if.sv -----
// Generic valid/ready channel carrying one word of a parameterized type.
// Instantiated with the word types of tadpcm_pkg; no other dependencies.
interface tadpcm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/tadpcm_alu.sv -----
// Shared multiply-accumulate unit of the decoder: one 17x17 signed multiplier,
// a prediction accumulator and the final Q12 shift, add and 16-bit clamp. Uses tadpcm_pkg.
module tadpcm_alu (
  input  logic                  clk,
  input  tadpcm_pkg::alu_req_t  req,
  output logic signed [15:0]    sample
);
  import tadpcm_pkg::*;

  logic signed [33:0] prod;
  logic signed [32:0] acc_r;
  logic signed [32:0] acc_nxt;
  logic signed [20:0] pred;
  logic signed [21:0] sum;

  assign prod = req.op_a * req.op_b;

  always_comb begin
    unique case (req.op)
      ALU_LOAD: acc_nxt = $signed(prod[32:0]);
      ALU_MAC:  acc_nxt = acc_r + $signed(prod[32:0]);
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign pred = $signed(acc_r[32:12]);
  assign sum  = $signed({{2{prod[19]}}, prod[19:0]}) + $signed({pred[20], pred});

  always_comb begin
    priority if (sum < SUM_MIN) begin
      sample = SAMPLE_MIN;
    end else if (sum > SUM_MAX) begin
      sample = SAMPLE_MAX;
    end else begin
      sample = $signed(sum[15:0]);
    end
  end

endmodule

// ----- sv/two_tap_adpcm_frame_decoder_unit.sv -----
// Two-tap ADPCM frame decoder: one stream byte in, up to two PCM samples out.
// Scale bytes are only stored on acceptance. A data byte is accepted in ST_IDLE, and each nibble
// then passes ST_MUL_A, ST_MUL_B and ST_MUL_C (two multiply-accumulates, the scale product with
// clamp) and ST_EMIT (the result load), which waits while a sample to emit finds the output full.
// All work goes through the one shared multiplier in tadpcm_alu, so bytes are taken one at a time.
// Synchronous active-low reset clears the frame state, histories and configuration registers to defaults.
module two_tap_adpcm_frame_decoder_unit (
  input logic          clk,
  input logic          rst_n,
  tadpcm_chan_if.sink   in_if,
  tadpcm_chan_if.source out_if,
  tadpcm_chan_if.sink   cfg_if
);
  import tadpcm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL_A = 5'b00010,
    ST_MUL_B = 5'b00100,
    ST_MUL_C = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0] coef1_r, coef1_nxt;
  logic signed [15:0] coef2_r, coef2_nxt;
  logic [1:0]         chan_cnt_r, chan_cnt_nxt;
  logic [31:0]        total_r, total_nxt;

  logic [4:0]         byte_pos_r, byte_pos_nxt;
  logic               chan_r, chan_nxt;
  logic [7:0]         scale_hi_r, scale_hi_nxt;
  logic signed [16:0] scale_r, scale_nxt;
  logic signed [15:0] hist_new_r [MAX_CHANNELS];
  logic signed [15:0] hist_new_nxt [MAX_CHANNELS];
  logic signed [15:0] hist_old_r [MAX_CHANNELS];
  logic signed [15:0] hist_old_nxt [MAX_CHANNELS];
  logic [31:0]        base_r, base_nxt;

  logic [7:0]         byte_r, byte_nxt;
  logic               cur_ch_r, cur_ch_nxt;
  logic [31:0]        idx_r, idx_nxt;
  logic [1:0]         emit_r, emit_nxt;
  logic [1:0]         done_r, done_nxt;
  logic               nib_sel_r, nib_sel_nxt;
  logic signed [15:0] sample_r, sample_nxt;
  res_word_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  alu_req_t           alu_req;
  logic signed [15:0] alu_sample;

  logic               start;
  logic               in_acc;
  logic [4:0]         pos_eff;
  logic [4:0]         pos_inc;
  logic [4:0]         pos_m2;
  logic [31:0]        base_eff;
  logic               ch_eff;
  logic [32:0]        idx0;
  logic [32:0]        idx1;
  logic [32:0]        idx2;
  logic [32:0]        total33;
  logic [32:0]        base_sum;
  logic               last_ch;
  logic               out_free;
  logic [3:0]         nib;

  tadpcm_alu u_alu (
    .clk    (clk),
    .req    (alu_req),
    .sample (alu_sample)
  );

  assign in_if.ready    = (state_r == ST_IDLE);
  assign cfg_if.ready   = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_r;

  assign in_acc   = in_if.valid && in_if.ready;
  assign start    = in_if.payload.stream_start;
  assign pos_eff  = start ? 5'd0 : byte_pos_r;
  assign base_eff = start ? 32'd0 : base_r;
  assign ch_eff   = start ? 1'b0 : chan_r;
  assign pos_inc  = pos_eff + 5'd1;
  assign pos_m2   = pos_eff - 5'd2;
  assign total33  = {1'b0, total_r};
  assign idx0     = {1'b0, base_eff} + {28'd0, pos_m2[3:0], 1'b0};
  assign idx1     = idx0 + 33'd1;
  assign idx2     = idx0 + 33'd2;
  assign base_sum = {1'b0, base_eff} + 33'(SAMPLES_PER_FRAME);
  assign last_ch  = ch_eff || (chan_cnt_r < 2'(MAX_CHANNELS));
  assign out_free = !out_valid_r || out_if.ready;
  assign nib      = nib_sel_r ? byte_r[3:0] : byte_r[7:4];

  always_comb begin
    alu_req.op   = ALU_HOLD;
    alu_req.op_a = {coef1_r[15], coef1_r};
    alu_req.op_b = {hist_new_r[cur_ch_r][15], hist_new_r[cur_ch_r]};
    unique case (state_r)
      ST_MUL_A: begin
        alu_req.op = ALU_LOAD;
      end
      ST_MUL_B: begin
        alu_req.op   = ALU_MAC;
        alu_req.op_a = {coef2_r[15], coef2_r};
        alu_req.op_b = {hist_old_r[cur_ch_r][15], hist_old_r[cur_ch_r]};
      end
      ST_MUL_C: begin
        alu_req.op   = ALU_FINISH;
        alu_req.op_a = {{13{nib[3]}}, nib};
        alu_req.op_b = scale_r;
      end
      default: begin
        alu_req.op = ALU_HOLD;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    coef1_nxt     = coef1_r;
    coef2_nxt     = coef2_r;
    chan_cnt_nxt  = chan_cnt_r;
    total_nxt     = total_r;
    byte_pos_nxt  = byte_pos_r;
    chan_nxt      = chan_r;
    scale_hi_nxt  = scale_hi_r;
    scale_nxt     = scale_r;
    hist_new_nxt  = hist_new_r;
    hist_old_nxt  = hist_old_r;
    base_nxt      = base_r;
    byte_nxt      = byte_r;
    cur_ch_nxt    = cur_ch_r;
    idx_nxt       = idx_r;
    emit_nxt      = emit_r;
    done_nxt      = done_r;
    nib_sel_nxt   = nib_sel_r;
    sample_nxt    = sample_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;

    if (cfg_if.valid) begin
      unique case (cfg_if.payload.reg_index)
        CFG_COEF_FIRST:    coef1_nxt    = $signed(cfg_if.payload.wdata[15:0]);
        CFG_COEF_SECOND:   coef2_nxt    = $signed(cfg_if.payload.wdata[15:0]);
        CFG_CHANNEL_COUNT: chan_cnt_nxt = cfg_if.payload.wdata[1:0];
        CFG_TOTAL:         total_nxt    = cfg_if.payload.wdata;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (start) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
              hist_new_nxt[i] = '0;
              hist_old_nxt[i] = '0;
            end
          end
          priority if (pos_eff == 5'd0) begin
            scale_hi_nxt = in_if.payload.stream_byte;
          end else if (pos_eff == 5'd1) begin
            scale_nxt = $signed({scale_hi_r[7], scale_hi_r, in_if.payload.stream_byte})
                        + 17'sd1;
          end else begin
            byte_nxt    = in_if.payload.stream_byte;
            cur_ch_nxt  = ch_eff;
            idx_nxt     = idx0[31:0];
            emit_nxt    = {idx1 < total33, idx0 < total33};
            done_nxt    = {idx2 == total33, idx1 == total33};
            nib_sel_nxt = 1'b0;
            state_nxt   = ST_MUL_A;
          end
          if (pos_inc == FRAME_BYTES) begin
            byte_pos_nxt = 5'd0;
            if (last_ch) begin
              chan_nxt = 1'b0;
              base_nxt = base_sum[32] ? 32'hFFFF_FFFF : base_sum[31:0];
            end else begin
              chan_nxt = 1'b1;
              base_nxt = base_eff;
            end
          end else begin
            byte_pos_nxt = pos_inc;
            chan_nxt     = ch_eff;
            base_nxt     = base_eff;
          end
        end
      end
      ST_MUL_A: begin
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        hist_old_nxt[cur_ch_r] = hist_new_r[cur_ch_r];
        hist_new_nxt[cur_ch_r] = alu_sample;
        sample_nxt             = alu_sample;
        state_nxt              = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_r[nib_sel_r] || out_free) begin
          if (emit_r[nib_sel_r]) begin
            out_nxt.pcm_sample   = sample_r;
            out_nxt.channel_id   = cur_ch_r;
            out_nxt.sample_index = nib_sel_r ? idx_r + 32'd1 : idx_r;
            out_nxt.last_of_byte = nib_sel_r || !emit_r[1];
            out_nxt.stream_done  = done_r[nib_sel_r];
            out_valid_nxt        = 1'b1;
          end
          if (nib_sel_r) begin
            state_nxt = ST_IDLE;
          end else begin
            nib_sel_nxt = 1'b1;
            state_nxt   = ST_MUL_A;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      coef1_r     <= COEF_FIRST_RESET;
      coef2_r     <= COEF_SECOND_RESET;
      chan_cnt_r  <= 2'd1;
      total_r     <= 32'd1;
      byte_pos_r  <= '0;
      chan_r      <= 1'b0;
      scale_hi_r  <= '0;
      scale_r     <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist_new_r[i] <= '0;
        hist_old_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      coef1_r     <= coef1_nxt;
      coef2_r     <= coef2_nxt;
      chan_cnt_r  <= chan_cnt_nxt;
      total_r     <= total_nxt;
      byte_pos_r  <= byte_pos_nxt;
      chan_r      <= chan_nxt;
      scale_hi_r  <= scale_hi_nxt;
      scale_r     <= scale_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
      hist_new_r  <= hist_new_nxt;
      hist_old_r  <= hist_old_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    cur_ch_r  <= cur_ch_nxt;
    idx_r     <= idx_nxt;
    emit_r    <= emit_nxt;
    done_r    <= done_nxt;
    nib_sel_r <= nib_sel_nxt;
    sample_r  <= sample_nxt;
    out_r     <= out_nxt;
  end

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r < FRAME_BYTES)
    else $error("Byte position left the frame.");

  a_index_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.payload.sample_index < total_r)
    else $error("Sample emitted at or past the total.");

  a_done_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.payload.stream_done)
      |-> (out_if.payload.sample_index == total_r - 32'd1))
    else $error("Done flag on a sample that is not the final one.");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && emit_r[nib_sel_r] && out_free)
      |=> (out_if.valid && out_if.payload.channel_id == $past(cur_ch_r)))
    else $error("Emitted sample did not reach the output register.");

endmodule

// ----- sim/two_tap_adpcm_frame_decoder_unit_tb.sv -----
// Self-checking testbench for the two-tap ADPCM frame decoder: random streams of
// frames against an in-line predictor of samples. Depends on tadpcm_pkg and tadpcm_chan_if.
`timescale 1ns / 1ps

module two_tap_adpcm_frame_decoder_unit_tb;
  import tadpcm_pkg::*;

  localparam logic [127:0] FULL_SCALE_BODY = 128'h778880080FF000FF7FF71234569ABCDE;
  localparam logic [39:0]  RESTART_BODY    = 40'h778811EE70;

  logic clk;
  logic rst_n;

  tadpcm_chan_if #(.T(in_word_t))  in_ch ();
  tadpcm_chan_if #(.T(res_word_t)) out_ch ();
  tadpcm_chan_if #(.T(cfg_word_t)) cfg_ch ();

  two_tap_adpcm_frame_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  logic signed [15:0] coef_new_w;
  logic signed [15:0] coef_old_w;
  logic [1:0]         chan_cfg;
  logic [31:0]        total_cfg;

  int unsigned        byte_pos;
  bit                 cur_ch;
  logic [7:0]         scale_hi;
  int                 frame_scale;
  logic signed [15:0] hist_new [2];
  logic signed [15:0] hist_old [2];
  logic [31:0]        base_idx;

  in_word_t    pending_bytes [$];
  res_word_t   expected_samples [$];
  int unsigned bytes_queued = 0;
  int          errors = 0;

  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  logic        quiet = 1'b0;
  logic        rx_hold = 1'b0;
  bit          hold_go = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [15:0] next_sample(logic [3:0] nib);
    longint acc;
    longint s;
    acc = longint'(coef_new_w) * longint'(hist_new[cur_ch])
        + longint'(coef_old_w) * longint'(hist_old[cur_ch]);
    s = longint'($signed(nib)) * longint'(frame_scale) + (acc >>> 12);
    if (s < SAMPLE_MIN) s = SAMPLE_MIN;
    else if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    hist_old[cur_ch] = hist_new[cur_ch];
    hist_new[cur_ch] = 16'(s);
    return 16'(s);
  endfunction

  function automatic void decode_byte(in_word_t w);
    res_word_t cand;
    res_word_t held;
    bit        have;
    longint    idx;
    int        eff;
    have = 1'b0;
    if (w.stream_start) begin
      hist_new[0] = '0;
      hist_new[1] = '0;
      hist_old[0] = '0;
      hist_old[1] = '0;
      byte_pos = 0;
      cur_ch = 1'b0;
      base_idx = '0;
    end
    if (byte_pos == 0) begin
      scale_hi = w.stream_byte;
    end else if (byte_pos == 1) begin
      frame_scale = int'($signed({scale_hi, w.stream_byte})) + 1;
    end else begin
      for (int k = 0; k < 2; k++) begin
        cand.pcm_sample = next_sample(k ? w.stream_byte[3:0] : w.stream_byte[7:4]);
        idx = longint'(base_idx) + 2 * (byte_pos - 2) + k;
        if (idx < longint'(total_cfg)) begin
          cand.channel_id   = cur_ch;
          cand.sample_index = 32'(idx);
          cand.last_of_byte = 1'b0;
          cand.stream_done  = (idx + 1 == longint'(total_cfg));
          if (have) expected_samples.push_back(held);
          held = cand;
          have = 1'b1;
        end
      end
      if (have) begin
        held.last_of_byte = 1'b1;
        expected_samples.push_back(held);
      end
    end
    byte_pos++;
    if (byte_pos >= FRAME_BYTES_N) begin
      byte_pos = 0;
      eff = (chan_cfg == 0) ? 1 : ((chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chan_cfg);
      if (int'(cur_ch) + 1 >= eff) begin
        cur_ch = 1'b0;
        if (base_idx > 32'hFFFF_FFFF - SAMPLES_PER_FRAME) base_idx = '1;
        else base_idx += SAMPLES_PER_FRAME;
      end else begin
        cur_ch = ~cur_ch;
      end
    end
  endfunction

  function automatic void check_field(string field, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  // A word leaves the queue only after the previous one was taken.
  always @(posedge clk) begin : drive_bytes
    in_word_t nxt;
    logic     give;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.payload);
      if (!in_ch.valid || in_ch.ready) begin
        give = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(0, 14);
        end else if (pending_bytes.size() > 0) begin
          nxt = pending_bytes.pop_front();
          give = 1'b1;
        end
        in_ch.valid <= give;
        if (give) in_ch.payload <= nxt;
      end
    end
  end

  always @(posedge clk) begin : watch_samples
    res_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample %0d on channel %0d arrived with nothing expected",
                 $signed(out_ch.payload.pcm_sample), out_ch.payload.channel_id);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          check_field("pcm_sample", $signed(want.pcm_sample),
                      $signed(out_ch.payload.pcm_sample));
          check_field("channel_id", want.channel_id, out_ch.payload.channel_id);
          check_field("sample_index", want.sample_index, out_ch.payload.sample_index);
          check_field("last_of_byte", want.last_of_byte, out_ch.payload.last_of_byte);
          check_field("stream_done", want.stream_done, out_ch.payload.stream_done);
        end
      end
      if (rx_gap > 0) rx_gap--;
      else if (!quiet && $urandom_range(0, 11) == 0) rx_gap = $urandom_range(1, 15);
      out_ch.ready <= !rx_hold && rx_gap == 0;
    end
  end

  initial begin : long_backpressure
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #12ms;
    $error("timed out with %0d samples still expected", expected_samples.size());
    $display("simulation failed");
    $finish;
  end

  function automatic void queue_byte(logic [7:0] b, logic start);
    pending_bytes.push_back({b, start});
    bytes_queued++;
  endfunction

  // Mostly whole frames opened by a start word; some are cut short, continue the
  // previous stream, or carry a stray start mid-frame.
  function automatic void queue_stream(int unsigned frames);
    int unsigned len;
    logic [7:0]  b;
    len = frames * FRAME_BYTES_N;
    if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i % FRAME_BYTES_N == 0 && $urandom_range(0, 3) != 0) b = {8{b[0]}};
      queue_byte(b, (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 99) == 0));
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= {idx, data};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_COEF_FIRST:    coef_new_w = data[15:0];
      CFG_COEF_SECOND:   coef_old_w = data[15:0];
      CFG_CHANNEL_COUNT: chan_cfg   = data[1:0];
      CFG_TOTAL:         total_cfg  = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || expected_samples.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] c_new, logic [15:0] c_old, logic [1:0] chans,
                           logic [31:0] total, int unsigned n_bytes);
    int unsigned first;
    drain();
    write_reg(CFG_COEF_FIRST, 32'(c_new));
    write_reg(CFG_COEF_SECOND, 32'(c_old));
    write_reg(CFG_CHANNEL_COUNT, 32'(chans));
    write_reg(CFG_TOTAL, total);
    first = bytes_queued;
    while (bytes_queued - first < n_bytes) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        queue_stream($urandom_range(1, 6));
      end
    end
  endtask

  initial begin : stimulus
    coef_new_w  = COEF_FIRST_RESET;
    coef_old_w  = COEF_SECOND_RESET;
    chan_cfg    = 2'd1;
    total_cfg   = 32'd1;
    byte_pos    = 0;
    cur_ch      = 1'b0;
    scale_hi    = '0;
    frame_scale = 0;
    hist_new[0] = '0;
    hist_new[1] = '0;
    hist_old[0] = '0;
    hist_old[1] = '0;
    base_idx    = '0;

    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Full positive scale drives both clamps, then a restart opens a frame that is cut short.
    run_phase(COEF_FIRST_RESET, COEF_SECOND_RESET, 2'd1, 32'd100, 0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hFF, 1'b0);
    for (int i = 0; i < 16; i++) queue_byte(FULL_SCALE_BODY[127 - 8 * i -: 8], 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h00, 1'b0);
    for (int i = 0; i < 5; i++) queue_byte(RESTART_BODY[39 - 8 * i -: 8], 1'b0);

    run_phase(16'($urandom), 16'($urandom), 2'd2, 32'd300, 170);
    hold_go = 1'b1;
    run_phase(16'h7FFF, 16'h8000, 2'd0, 32'hFFFF_FFFF, 170);
    run_phase(16'h8000, 16'h7FFF, 2'd3, $urandom_range(20, 80), 170);
    run_phase(16'($urandom), 16'($urandom), 2'd1, 32'd1, 120);
    run_phase(16'h0000, 16'h0000, 2'd2, 32'hFFFF_FFFF, 120);
    drain();
    quiet <= 1'b1;
    run_phase(16'($urandom), 16'($urandom), 2'($urandom_range(0, 3)),
              $urandom_range(50, 400), 170);
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
